@@ design/cdt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdt_pkg
// shared types, constants and letter functions of the codon translator
// ----------------------------------------------------------------------------
package cdt_pkg;

    localparam int POSITION_WIDTH  = 32;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int FIFO_DEPTH      = 4;
    localparam int FIFO_PTR_WIDTH  = $clog2(FIFO_DEPTH);
    localparam int TABLE_DEPTH     = 64;
    localparam int TABLE_IDX_WIDTH = $clog2(TABLE_DEPTH);
    localparam int MARK_BEATS      = 5;
    localparam int BEAT_WIDTH      = $clog2(MARK_BEATS);

    localparam logic [7:0] CHAR_X      = 8'h58;
    localparam logic [7:0] CHAR_LPAREN = 8'h28;
    localparam logic [7:0] CHAR_RPAREN = 8'h29;

    localparam logic [2:0] CODE_BAD = 3'd4;

    // configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_REGION_START   = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_REGION_END     = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FRAME_OFFSET   = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_REVERSE_STRAND = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MARK_MODE      = 3'd4;

    typedef enum logic [1:0] {
        CMD_BASE  = 2'd0,
        CMD_END   = 2'd1,
        CMD_TABLE = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        JOB_LOOKUP = 2'd0,
        JOB_BAD    = 2'd1,
        JOB_END    = 2'd2,
        JOB_WRITE  = 2'd3
    } job_kind_t;

    // work handed from the front to the back
    typedef struct packed {
        job_kind_t                  kind;
        logic                       mark;
        logic [TABLE_IDX_WIDTH-1:0] idx;
        logic [7:0]                 c1;   // also the table letter on writes
        logic [7:0]                 c2;
        logic [7:0]                 c3;
    } job_t;

    function automatic logic [7:0] comp_letter(input logic [7:0] c);
        logic [7:0] r;
        begin
            case (c)
                8'h41:   r = 8'h54;  // A -> T
                8'h54:   r = 8'h41;
                8'h47:   r = 8'h43;  // G -> C
                8'h43:   r = 8'h47;
                8'h42:   r = 8'h56;  // B -> V
                8'h56:   r = 8'h42;
                8'h44:   r = 8'h48;  // D -> H
                8'h48:   r = 8'h44;
                8'h4B:   r = 8'h4D;  // K -> M
                8'h4D:   r = 8'h4B;
                default: r = c;
            endcase
            return r;
        end
    endfunction

    function automatic logic [2:0] base_code(input logic [7:0] c);
        logic [7:0] u;
        logic [2:0] r;
        begin
            u = (c inside {[8'h61:8'h7A]}) ? c - 8'd32 : c;
            case (u)
                8'h41:   r = 3'd0;
                8'h43:   r = 3'd1;
                8'h47:   r = 3'd2;
                8'h54:   r = 3'd3;
                8'h55:   r = 3'd3;
                default: r = CODE_BAD;
            endcase
            return r;
        end
    endfunction

endpackage

@@ design/cdt_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdt_front
// config registers, base counting, frame skipping and codon assembly
// ----------------------------------------------------------------------------
module cdt_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic [1:0]                           in_cmd,
    input  logic [7:0]                           in_base_char,
    input  logic [cdt_pkg::TABLE_IDX_WIDTH-1:0]  in_table_index,
    input  logic [7:0]                           in_table_char,
    input  logic                                 cfg_we,
    input  logic [cdt_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [cdt_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    output logic                                 push,
    output cdt_pkg::job_t                        push_job
);
    import cdt_pkg::*;

    logic [31:0]               region_start_reg;
    logic [31:0]               region_end_reg;
    logic [1:0]                frame_offset_reg;
    logic                      reverse_reg;
    logic                      mark_reg;

    logic [POSITION_WIDTH-1:0] pos_reg, pos_next;
    logic [7:0]                held1_reg, held1_next;
    logic [7:0]                held2_reg, held2_next;
    logic [1:0]                held_cnt_reg, held_cnt_next;
    logic                      halted_reg, halted_next;

    logic                      accept;
    cmd_t                      cmd;
    logic [7:0]                letter;
    logic [1:0]                skip;
    logic [POSITION_WIDTH:0]   first;
    logic [POSITION_WIDTH:0]   rel;
    logic [2:0]                k1, k2, k3;
    logic                      any_bad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_start_reg <= 32'd1;
            region_end_reg   <= 32'd0;
            frame_offset_reg <= 2'd1;
            reverse_reg      <= 1'b0;
            mark_reg         <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_REGION_START:   region_start_reg <= cfg_data[31:0];
                REG_REGION_END:     region_end_reg   <= cfg_data[31:0];
                REG_FRAME_OFFSET:   frame_offset_reg <= cfg_data[1:0];
                REG_REVERSE_STRAND: reverse_reg      <= cfg_data[0];
                REG_MARK_MODE:      mark_reg         <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        accept = in_valid && in_ready;
        cmd    = cmd_t'(in_cmd);
        letter = reverse_reg ? comp_letter(in_base_char) : in_base_char;
        skip   = (frame_offset_reg == 2'd0) ? 2'd0 : frame_offset_reg - 2'd1;
        first  = {1'b0, (region_start_reg == 32'd0) ? {POSITION_WIDTH{1'b0}}
                                : POSITION_WIDTH'(region_start_reg - 32'd1)}
                 + (POSITION_WIDTH+1)'(skip);
        rel    = {1'b0, pos_reg} - (POSITION_WIDTH+1)'(skip);
        k1     = base_code(held1_reg);
        k2     = base_code(held2_reg);
        k3     = base_code(letter);
        any_bad = (k1 == CODE_BAD) || (k2 == CODE_BAD) || (k3 == CODE_BAD);

        pos_next      = pos_reg;
        held1_next    = held1_reg;
        held2_next    = held2_reg;
        held_cnt_next = held_cnt_reg;
        halted_next   = halted_reg;

        push          = 1'b0;
        push_job.kind = JOB_LOOKUP;
        push_job.mark = mark_reg;
        push_job.idx  = {k1[1:0], k2[1:0], k3[1:0]};
        push_job.c1   = held1_reg;
        push_job.c2   = held2_reg;
        push_job.c3   = letter;

        if (accept)
        begin
            case (cmd)
                CMD_END:
                begin
                    push          = 1'b1;
                    push_job.kind = JOB_END;
                    pos_next      = '0;
                    held1_next    = 8'd0;
                    held2_next    = 8'd0;
                    held_cnt_next = 2'd0;
                    halted_next   = 1'b0;
                end
                CMD_TABLE:
                begin
                    push          = 1'b1;
                    push_job.kind = JOB_WRITE;
                    push_job.idx  = in_table_index;
                    push_job.c1   = in_table_char;
                end
                CMD_BASE:
                begin
                    if (pos_reg != {POSITION_WIDTH{1'b1}})
                    begin
                        pos_next = pos_reg + 1'b1;
                        if (!halted_reg && ({1'b0, pos_reg} >= first))
                        begin
                            case (held_cnt_reg)
                                2'd0:
                                begin
                                    // region end is checked at codon start
                                    if ((region_end_reg != 32'd0) &&
                                        (rel >= (POSITION_WIDTH+1)'(region_end_reg)))
                                        halted_next = 1'b1;
                                    else
                                    begin
                                        held1_next    = letter;
                                        held_cnt_next = 2'd1;
                                    end
                                end
                                2'd1:
                                begin
                                    held2_next    = letter;
                                    held_cnt_next = 2'd2;
                                end
                                default:
                                begin
                                    held_cnt_next = 2'd0;
                                    push          = 1'b1;
                                    push_job.kind = any_bad ? JOB_BAD : JOB_LOOKUP;
                                end
                            endcase
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            held1_reg    <= 8'd0;
            held2_reg    <= 8'd0;
            held_cnt_reg <= 2'd0;
            halted_reg   <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            held1_reg    <= held1_next;
            held2_reg    <= held2_next;
            held_cnt_reg <= held_cnt_next;
            halted_reg   <= halted_next;
        end
    end

endmodule

@@ design/cdt_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdt_fifo
// short job queue between front and back
// ----------------------------------------------------------------------------
module cdt_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cdt_pkg::job_t push_job,
    output logic          push_ready,
    input  logic          pop,
    output logic          head_valid,
    output cdt_pkg::job_t head_job
);
    import cdt_pkg::*;

    job_t                    mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_WIDTH-1:0] wr_reg, wr_next;
    logic [FIFO_PTR_WIDTH-1:0] rd_reg, rd_next;
    logic [FIFO_PTR_WIDTH:0]   cnt_reg, cnt_next;
    logic                      do_push, do_pop;

    always_comb
    begin
        push_ready = (cnt_reg != (FIFO_PTR_WIDTH+1)'(FIFO_DEPTH));
        head_valid = (cnt_reg != '0);
        head_job   = mem_reg[rd_reg];
        do_push    = push && push_ready;
        do_pop     = pop && head_valid;
        wr_next    = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next    = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next   = cnt_reg + (FIFO_PTR_WIDTH+1)'(do_push)
                             - (FIFO_PTR_WIDTH+1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ design/cdt_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdt_back
// codon table, lookup, bad codon expansion and output register
// ----------------------------------------------------------------------------
module cdt_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  cdt_pkg::job_t head_job,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_char,
    output logic          out_bad,
    output logic          out_end,
    output logic          out_any_bad,
    output logic          out_last
);
    import cdt_pkg::*;

    logic [7:0]            table_mem [TABLE_DEPTH];
    logic [7:0]            rd_reg;
    job_t                  job_reg;
    logic                  job_valid_reg;
    logic [BEAT_WIDTH-1:0] beat_reg;
    logic                  drop_reg;
    logic                  bad_seen_reg;

    logic                  ov_reg;
    logic [7:0]            char_reg;
    logic                  bad_reg, end_reg, any_reg, last_reg;

    logic                  load_ok;
    logic                  emit;
    logic                  done;
    logic                  emit_fire;
    logic                  job_done;
    logic                  set_drop;
    logic [7:0]            e_char;
    logic                  e_bad, e_end, e_any, e_last;
    logic                  final_beat;

    always_comb
    begin
        load_ok    = !ov_reg || out_ready;
        final_beat = (beat_reg == BEAT_WIDTH'(MARK_BEATS - 1));
        emit       = 1'b0;
        done       = 1'b0;
        set_drop   = 1'b0;
        e_char     = 8'd0;
        e_bad      = 1'b0;
        e_end      = 1'b0;
        e_any      = 1'b0;
        e_last     = 1'b1;

        case (job_reg.kind)
            JOB_LOOKUP:
            begin
                if (drop_reg)
                    done = 1'b1;
                else if (rd_reg == 8'd0)
                begin
                    // empty entry halts the sequence
                    done     = 1'b1;
                    set_drop = 1'b1;
                end
                else
                begin
                    emit   = 1'b1;
                    e_char = rd_reg;
                    done   = load_ok;
                end
            end
            JOB_BAD:
            begin
                if (drop_reg)
                    done = 1'b1;
                else
                begin
                    emit  = 1'b1;
                    e_bad = 1'b1;
                    if (job_reg.mark)
                    begin
                        case (beat_reg)
                            3'd0:    e_char = CHAR_LPAREN;
                            3'd1:    e_char = job_reg.c1;
                            3'd2:    e_char = job_reg.c2;
                            3'd3:    e_char = job_reg.c3;
                            default: e_char = CHAR_RPAREN;
                        endcase
                        e_last = final_beat;
                        done   = load_ok && final_beat;
                    end
                    else
                    begin
                        e_char = CHAR_X;
                        done   = load_ok;
                    end
                end
            end
            JOB_END:
            begin
                emit  = 1'b1;
                e_end = 1'b1;
                e_any = bad_seen_reg;
                done  = load_ok;
            end
            default: done = 1'b1;
        endcase

        emit_fire = job_valid_reg && emit && load_ok;
        job_done  = job_valid_reg && done;
        pop       = head_valid && (!job_valid_reg || job_done);
    end

    // table port: write on table jobs, registered read for every popped job
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (head_job.kind == JOB_WRITE)
                table_mem[head_job.idx] <= head_job.c1;
            rd_reg  <= table_mem[head_job.idx];
            job_reg <= head_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            beat_reg      <= '0;
            drop_reg      <= 1'b0;
            bad_seen_reg  <= 1'b0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                job_valid_reg <= (head_job.kind != JOB_WRITE);
                beat_reg      <= '0;
            end
            else if (job_done)
                job_valid_reg <= 1'b0;
            else if (emit_fire)
                beat_reg <= beat_reg + 1'b1;

            if (job_valid_reg && set_drop)
                drop_reg <= 1'b1;
            else if (emit_fire && e_end)
                drop_reg <= 1'b0;

            if (emit_fire && e_end)
                bad_seen_reg <= 1'b0;
            else if (emit_fire && e_bad)
                bad_seen_reg <= 1'b1;

            if (emit_fire)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            char_reg <= e_char;
            bad_reg  <= e_bad;
            end_reg  <= e_end;
            any_reg  <= e_any;
            last_reg <= e_last;
        end
    end

    assign out_valid   = ov_reg;
    assign out_char    = char_reg;
    assign out_bad     = bad_reg;
    assign out_end     = end_reg;
    assign out_any_bad = any_reg;
    assign out_last    = last_reg;

endmodule

@@ design/codon_translator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// codon_translator
// streaming nucleotide to amino acid translator with loadable codon table
// ----------------------------------------------------------------------------
// path: queue entry, then job and table read registers, then the output register
// throughput: one input beat per cycle while the queue has space; a marked bad
//   codon holds the back end for five output beats, absorbed by the four-entry job queue
// reset: config registers to defaults, sequence state and queue cleared;
//   the codon table is not cleared and holds garbage until written
module codon_translator (
    input  logic                                clk,
    input  logic                                rst_n,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [23:0]                         s_tdata,  // base_char, table_index, table_char
    input  logic [1:0]                          s_tuser,  // cmd
    // output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,  // out_char
    output logic [2:0]                          m_tuser,  // bad_codon, seq_end, any_bad_seen
    output logic                                m_tlast,  // last
    // config writes
    input  logic                                cfg_we,
    input  logic [cdt_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [cdt_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
    import cdt_pkg::*;

    // front to queue
    logic push;
    job_t push_job;
    logic push_ready;

    // queue to back
    logic pop;
    logic head_valid;
    job_t head_job;

    logic out_bad, out_end, out_any_bad;

    // the front never stalls on its own; it only waits for queue space
    assign s_tready = push_ready;

    // front: counts bases, skips to region and frame, builds codons
    cdt_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_cmd         (s_tuser),
        .in_base_char   (s_tdata[7:0]),
        .in_table_index (s_tdata[13:8]),
        .in_table_char  (s_tdata[21:14]),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .push           (push),
        .push_job       (push_job)
    );

    // job queue decouples base intake from letter output
    cdt_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .push_ready (push_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // back: table writes and lookups in job order, halt on empty entry,
    // bad codon expansion and the output register
    cdt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_job    (head_job),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_char    (m_tdata),
        .out_bad     (out_bad),
        .out_end     (out_end),
        .out_any_bad (out_any_bad),
        .out_last    (m_tlast)
    );

    assign m_tuser = {out_any_bad, out_end, out_bad};

endmodule

@@ sim/cdt_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdt_check
// watches the codon translator streams, predicts every output beat and
// compares the beats the block delivers against the predicted letters
// ----------------------------------------------------------------------------
module cdt_check (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [23:0]                         s_tdata,   // base_char, table_index, table_char
    input  logic [1:0]                          s_tuser,   // cmd
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [7:0]                          m_tdata,   // out_char
    input  logic [2:0]                          m_tuser,   // bad_codon, seq_end, any_bad_seen
    input  logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [cdt_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [cdt_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    output int                                  letters_waiting,
    output int                                  mismatches
);
    import cdt_pkg::*;

    localparam int REPORT_CAP = 100;

    typedef struct packed {
        logic [7:0] ch;
        logic       bad;
        logic       seq_end;
        logic       any_bad;
        logic       last;
    } letter_t;

    letter_t letters_due[$];

    logic [31:0] start_pos;
    logic [31:0] end_pos;
    logic [1:0]  frame;
    logic        rev;
    logic        mark;

    logic [POSITION_WIDTH-1:0] base_count;
    logic [7:0]                first_base;
    logic [7:0]                second_base;
    int unsigned               held;
    logic                      halted;
    logic                      saw_bad;
    logic [7:0]                amino [TABLE_DEPTH];

    function automatic logic [7:0] pair_of(input logic [7:0] c);
        case (c)
            "A": return "T";
            "T": return "A";
            "G": return "C";
            "C": return "G";
            "B": return "V";
            "V": return "B";
            "D": return "H";
            "H": return "D";
            "K": return "M";
            "M": return "K";
            default: return c;
        endcase
    endfunction

    function automatic logic [2:0] code_of(input logic [7:0] c);
        logic [7:0] up;
        up = (c >= "a" && c <= "z") ? c - 8'd32 : c;
        case (up)
            "A": return 3'd0;
            "C": return 3'd1;
            "G": return 3'd2;
            "T", "U": return 3'd3;
            default: return CODE_BAD;
        endcase
    endfunction

    function automatic void due_letter(input logic [7:0] ch, input logic bad,
                                       input logic se, input logic any, input logic last);
        letters_due.push_back('{ch, bad, se, any, last});
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < REPORT_CAP)
            $display("[%0t] mismatch: %s", $realtime, what);
        mismatches = mismatches + 1;
    endtask

    task automatic clear_run();
        base_count  = '0;
        first_base  = '0;
        second_base = '0;
        held        = 0;
        halted      = 1'b0;
        saw_bad     = 1'b0;
    endtask

    task automatic take_beat(input logic [1:0] cmd, input logic [23:0] data);
        logic [7:0]                c;
        logic [2:0]                k1;
        logic [2:0]                k2;
        logic [2:0]                k3;
        logic [1:0]                fr;
        logic [31:0]               from;
        logic [POSITION_WIDTH:0]   skip;
        logic [POSITION_WIDTH:0]   rel;
        logic [POSITION_WIDTH-1:0] pos;
        logic [7:0]                aa;
        case (cmd)
            CMD_END:
            begin
                due_letter(8'h00, 1'b0, 1'b1, saw_bad, 1'b1);
                clear_run();
            end
            CMD_TABLE:
            begin
                amino[data[13:8]] = data[21:14];
            end
            CMD_BASE:
            begin
                // a full position counter swallows every further base
                if (base_count != '1)
                begin
                    pos        = base_count;
                    base_count = base_count + 1'b1;
                    if (!halted)
                    begin
                        c    = rev ? pair_of(data[7:0]) : data[7:0];
                        fr   = (frame == 2'd0) ? 2'd1 : frame;
                        from = (start_pos == 32'd0) ? 32'd1 : start_pos;
                        skip = from - 1'b1 + fr - 1'b1;
                        if ({1'b0, pos} >= skip)
                        begin
                            if (held == 0)
                            begin
                                rel = pos - (fr - 1'b1);
                                if (end_pos != 32'd0 && rel >= end_pos)
                                    halted = 1'b1;
                                else
                                begin
                                    first_base = c;
                                    held       = 1;
                                end
                            end
                            else if (held == 1)
                            begin
                                second_base = c;
                                held        = 2;
                            end
                            else
                            begin
                                held = 0;
                                k1   = code_of(first_base);
                                k2   = code_of(second_base);
                                k3   = code_of(c);
                                if (k1 == CODE_BAD || k2 == CODE_BAD || k3 == CODE_BAD)
                                begin
                                    saw_bad = 1'b1;
                                    if (mark)
                                    begin
                                        due_letter(CHAR_LPAREN, 1'b1, 1'b0, 1'b0, 1'b0);
                                        due_letter(first_base,  1'b1, 1'b0, 1'b0, 1'b0);
                                        due_letter(second_base, 1'b1, 1'b0, 1'b0, 1'b0);
                                        due_letter(c,           1'b1, 1'b0, 1'b0, 1'b0);
                                        due_letter(CHAR_RPAREN, 1'b1, 1'b0, 1'b0, 1'b1);
                                    end
                                    else
                                        due_letter(CHAR_X, 1'b1, 1'b0, 1'b0, 1'b1);
                                end
                                else
                                begin
                                    aa = amino[{k1[1:0], k2[1:0], k3[1:0]}];
                                    if (aa == 8'h00)
                                        halted = 1'b1;
                                    else
                                        due_letter(aa, 1'b0, 1'b0, 1'b0, 1'b1);
                                end
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_letter();
        letter_t want;
        if (letters_due.size() == 0)
        begin
            report_mismatch($sformatf("beat with nothing due, char %h", m_tdata));
            return;
        end
        want = letters_due.pop_front();
        if (m_tdata !== want.ch)
            report_mismatch($sformatf("out_char %h, want %h", m_tdata, want.ch));
        if (m_tuser[0] !== want.bad)
            report_mismatch($sformatf("bad_codon %b, want %b", m_tuser[0], want.bad));
        if (m_tuser[1] !== want.seq_end)
            report_mismatch($sformatf("seq_end %b, want %b", m_tuser[1], want.seq_end));
        if (m_tuser[2] !== want.any_bad)
            report_mismatch($sformatf("any_bad_seen %b, want %b", m_tuser[2], want.any_bad));
        if (m_tlast !== want.last)
            report_mismatch($sformatf("last %b, want %b", m_tlast, want.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pos = 32'd1;
            end_pos   = 32'd0;
            frame     = 2'd1;
            rev       = 1'b0;
            mark      = 1'b0;
            clear_run();
            letters_due.delete();
            mismatches      = 0;
            letters_waiting <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_REGION_START:   start_pos = cfg_data[31:0];
                    REG_REGION_END:     end_pos   = cfg_data[31:0];
                    REG_FRAME_OFFSET:   frame     = cfg_data[1:0];
                    REG_REVERSE_STRAND: rev       = cfg_data[0];
                    REG_MARK_MODE:      mark      = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                take_beat(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                check_letter();
            letters_waiting <= letters_due.size();
        end
    end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives the codon translator with table loads, directed codons and random
// base runs under several register settings; cdt_check predicts and compares
// ----------------------------------------------------------------------------
module tb;
    import cdt_pkg::*;

    localparam logic [1:0] CMD_SPARE    = 2'd3;   // not a command, block ignores it
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         DRAIN_CYCLES = 16;     // queue depth plus pipeline, with margin
    localparam int         HOLD_CYCLES  = 80;
    localparam int         IDLE_PCT     = 22;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // base_char, table_index, table_char
    logic [1:0]  s_tuser  = '0;   // cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // out_char
    logic [2:0]  m_tuser;         // bad_codon, seq_end, any_bad_seen
    logic        m_tlast;

    logic                       cfg_we    = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data  = '0;

    int letters_waiting;
    int mismatches;

    // idling switches for each side, cleared for the stretch with no gaps
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    // each increment asks the receiver for one long hold-off
    int hold_asked = 0;
    int cycle_count = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    codon_translator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cdt_check u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .letters_waiting (letters_waiting),
        .mismatches      (mismatches)
    );

    // watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when one is asked for
    initial
    begin : receiver
        int hold_served;
        int hold_left;
        hold_served = 0;
        hold_left   = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && hold_served != hold_asked)
            begin
                hold_served = hold_served + 1;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                m_tready  <= 1'b0;
                hold_left = hold_left - 1;
            end
            else if (rx_idle_on)
                m_tready <= ($urandom_range(99) >= IDLE_PCT);
            else
                m_tready <= 1'b1;
        end
    end

    // one input beat; random gaps before it, then hold until taken
    task automatic send_beat(input logic [1:0] cmd, input logic [7:0] letter,
                             input logic [5:0] slot, input logic [7:0] acid);
        while (tx_idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, acid, slot, letter};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_base(input logic [7:0] letter);
        send_beat(CMD_BASE, letter, 6'($urandom), 8'($urandom));
    endtask

    task automatic send_end();
        send_beat(CMD_END, 8'($urandom), 6'($urandom), 8'($urandom));
    endtask

    task automatic send_table(input logic [5:0] slot, input logic [7:0] acid);
        send_beat(CMD_TABLE, 8'($urandom), slot, acid);
    endtask

    // writes all five registers back to back; only called with the block idle
    task automatic configure(input logic [31:0] from, input logic [31:0] till,
                             input logic [31:0] frame, input logic [31:0] rev,
                             input logic [31:0] mark);
        logic [CFG_INDEX_WIDTH-1:0] idx [5];
        logic [CFG_DATA_WIDTH-1:0]  val [5];
        idx = '{REG_REGION_START, REG_REGION_END, REG_FRAME_OFFSET,
                REG_REVERSE_STRAND, REG_MARK_MODE};
        val = '{from, till, frame, rev, mark};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // wait for every predicted letter, then let silent work finish
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (letters_waiting != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // mostly valid bases in either case, sometimes an ambiguity code or any byte
    function automatic logic [7:0] pick_letter();
        string good;
        string odd;
        int    roll;
        good = "ACGTUacgtu";
        odd  = "BDHKMNSVWbn";
        roll = $urandom_range(99);
        if (roll < 85)
            return good[$urandom_range(good.len() - 1)];
        else if (roll < 93)
            return odd[$urandom_range(odd.len() - 1)];
        else
            return 8'($urandom);
    endfunction

    // base runs, most closed by an end beat, with table rewrites and spare commands
    // mixed in; spare commands do not count toward the budget
    task automatic random_phase(input int budget);
        int sent;
        int run;
        int roll;
        sent = 0;
        while (sent < budget)
        begin
            run = $urandom_range(24, 2);
            for (int i = 0; i < run && sent < budget; i++)
            begin
                roll = $urandom_range(99);
                if (roll < 4)
                begin
                    // an empty entry now and then, to cut a run short
                    send_table(6'($urandom),
                               ($urandom_range(9) == 0) ? 8'h00 : 8'($urandom_range(255, 1)));
                    sent = sent + 1;
                end
                else if (roll < 7)
                    send_beat(CMD_SPARE, 8'($urandom), 6'($urandom), 8'($urandom));
                else
                begin
                    send_base(pick_letter());
                    sent = sent + 1;
                end
            end
            if ($urandom_range(9) != 0)
            begin
                send_end();
                sent = sent + 1;
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // load every entry so no codon ever reads an unwritten slot
        for (int k = 0; k < TABLE_DEPTH; k++)
            send_table(6'(k), (k == TABLE_DEPTH - 1) ? 8'hFF : 8'($urandom_range(255, 1)));
        drain();

        // forward strand, plain mode: normal codon, lowercase with U,
        // then a bad codon with an unknown letter and a zero byte
        configure(32'd1, 32'd0, 32'd1, 32'd0, 32'd0);
        send_base("A");
        send_base("T");
        send_base("G");
        send_base("a");
        send_base("c");
        send_base("u");
        send_base("A");
        send_base("N");
        send_base(8'h00);
        send_end();
        drain();

        // zero start and frame act as one; reverse strand with mark mode
        configure(32'd0, 32'd0, 32'd0, 32'd1, 32'd1);
        send_base("A");          // complements to T
        send_base("c");          // lowercase is left alone
        send_base("G");          // complements to C
        send_base("B");          // ambiguity code, complements to V
        send_base("x");
        send_base(8'hFF);        // marked codon, five beats
        send_table(6'd0, 8'h00); // empty the AAA entry
        send_base("T");
        send_base("T");
        send_base("T");          // reads the empty entry and halts
        send_base("G");          // halted, no beat
        send_end();
        send_table(6'd0, "M");
        drain();

        // random part under several settings
        configure(32'd1, 32'd0, {30'($urandom), 2'd2}, 32'd0, {31'($urandom), 1'b1});
        random_phase(12);
        drain();

        configure($urandom_range(10, 1), $urandom_range(60, 6), 32'd3,
                  {31'($urandom), 1'b1}, 32'd0);
        random_phase(12);
        drain();

        // region starts past any reachable position: only end beats answer
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd1);
        random_phase(6);
        drain();

        // no gaps on either side, and one long receiver hold-off so the
        // queue fills and the input stalls
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        configure(32'd1, 32'd0, 32'd1, 32'd0, 32'd1);
        hold_asked = hold_asked + 1;
        random_phase(26);
        drain();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;

        configure($urandom_range(4, 1), 32'd0, $urandom_range(3, 1),
                  $urandom_range(1), $urandom_range(1));
        random_phase(10);
        drain();

        // short region end so runs halt early
        configure($urandom_range(3, 1), $urandom_range(12, 1), $urandom_range(3),
                  $urandom_range(1), $urandom_range(1));
        random_phase(10);
        drain();

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
design/cdt_pkg.sv
design/cdt_front.sv
design/cdt_fifo.sv
design/cdt_back.sv
design/codon_translator.sv
sim/cdt_check.sv
sim/tb.sv
